// ----- design/add_carry_counter_random_defines.svh -----
// ---------------------------------------------------------------------------
// add_carry_counter_random assertion macros
// Shared property wrappers for the generator's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ADD_CARRY_COUNTER_RANDOM_DEFINES_SVH
`define ADD_CARRY_COUNTER_RANDOM_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ACCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ACCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/accr_pkg.sv -----
// ---------------------------------------------------------------------------
// accr_pkg
// Types and seed table constants for the add-with-carry counter generator.
// ---------------------------------------------------------------------------
package accr_pkg;

   localparam int NumWords = 6;
   localparam int WordWidth = 32;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [NumWords-1:0][WordWidth-1:0] words_type;

   typedef enum logic {
      KindDraw = 1'b0,
      KindSeed = 1'b1
   } kind_type;

   localparam words_type BaseTable = '{
      0: 32'hF22D0E56,
      1: 32'h883126E9,
      2: 32'hC624DD2F,
      3: 32'h0702C49C,
      4: 32'h9E353F7D,
      5: 32'h6FDF3B64
   };

   typedef struct packed {
      words_type words;
      word_type  random_word;
   } step_result_type;

endpackage

// ----- design/accr_step.sv -----
// ---------------------------------------------------------------------------
// accr_step
// Next-state logic: reseed from the table, or add-with-carry chain plus
// ripple increment for a draw.
// ---------------------------------------------------------------------------
module accr_step (
   input  accr_pkg::words_type       state,
   input  accr_pkg::kind_type        kind,
   input  accr_pkg::word_type        seed_value,
   output accr_pkg::step_result_type result
);

   accr_pkg::words_type chain_words;
   accr_pkg::words_type inc_words;
   accr_pkg::words_type seed_words;

   // add chain: word4 gets w5+w4 with true carry, then 3..0 compare on old word
   always_comb begin
      accr_pkg::word_type run;
      logic carry;
      chain_words = state;
      run = state[5] + state[4];
      carry = (run < state[5]) || (run < state[4]);
      chain_words[4] = run;
      for (int k = 3; k >= 0; k--) begin
         run = run + state[k] + accr_pkg::word_type'(carry);
         carry = (run < state[k]);
         chain_words[k] = run;
      end
   end

   // ripple increment from word5 down
   always_comb begin
      logic inc;
      inc = 1'b1;
      for (int k = accr_pkg::NumWords - 1; k >= 0; k--) begin
         inc_words[k] = chain_words[k] + accr_pkg::word_type'(inc);
         inc = inc && (chain_words[k] == '1);
      end
   end

   always_comb begin
      for (int k = 0; k < accr_pkg::NumWords; k++) begin
         seed_words[k] = accr_pkg::BaseTable[k] + seed_value;
      end
   end

   always_comb begin
      if (kind == accr_pkg::KindSeed) begin
         result.words = seed_words;
      end else begin
         result.words = inc_words;
      end
      result.random_word = inc_words[0];
   end

endmodule

// ----- design/add_carry_counter_random.sv -----
// ---------------------------------------------------------------------------
// add_carry_counter_random
// Six-word add-with-carry pseudo-random generator with a ripple counter.
// ---------------------------------------------------------------------------
// Input stream (req_): one beat per item. req_tuser is the kind (0 draws a
// word, 1 reseeds); req_tdata is the seed, looked at only on a reseed.
// Output stream (rsp_): one beat per draw carrying the new word0; a reseed
// gives no output beat.
// An accepted beat waits in the input register until it advances; it is then
// applied to the state, and a draw's word is loaded into the rsp_ output
// register at that same edge.
// Throughput: one item per cycle while no draw waits on a stalled output
// beat. The whole update (five chained 32-bit adds and the increment ripple)
// sits between the input register and the state and output registers.
// Reset (synchronous, active high) clears all six state words to zero and
// empties the input and output registers.
// When the receiver stalls, the waiting output beat holds; reseeds still
// drain, and one further draw can sit in the input register before
// req_tready drops.
// ---------------------------------------------------------------------------
`include "add_carry_counter_random_defines.svh"

module add_carry_counter_random (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] random_word
);

   logic                      in_valid_ff, in_valid_in;
   accr_pkg::kind_type        in_kind_ff;
   accr_pkg::word_type        in_seed_ff;
   accr_pkg::words_type       state_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   accr_pkg::word_type        rsp_data_ff;
   accr_pkg::step_result_type step_result;
   logic                      out_blocked;
   logic                      advance;
   logic                      req_take;

   accr_step u_step (
      .state      (state_ff),
      .kind       (in_kind_ff),
      .seed_value (in_seed_ff),
      .result     (step_result)
   );

   assign out_blocked = rsp_valid_ff && !rsp_tready;
   assign advance = in_valid_ff && ((in_kind_ff == accr_pkg::KindSeed) || !out_blocked);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance && (in_kind_ff == accr_pkg::KindDraw)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= step_result.words;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= accr_pkg::kind_type'(req_tuser);
         in_seed_ff <= req_tdata;
      end
      if (advance && (in_kind_ff == accr_pkg::KindDraw)) begin
         rsp_data_ff <= step_result.random_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ACCR_ASSERT_NEXT(a_draw_gives_beat, clock, reset,
      advance && (in_kind_ff == accr_pkg::KindDraw), rsp_valid_ff,
      "draw did not load an output beat")

   `ACCR_ASSERT_NEXT(a_seed_no_beat, clock, reset,
      advance && (in_kind_ff == accr_pkg::KindSeed) && !out_blocked, !rsp_valid_ff,
      "reseed produced an output beat")

   `ACCR_ASSERT_NEXT(a_word5_counts, clock, reset,
      advance && (in_kind_ff == accr_pkg::KindDraw),
      state_ff[5] == $past(state_ff[5]) + 32'd1,
      "word5 not incremented by a draw")

   `ACCR_ASSERT_NEXT(a_input_held, clock, reset,
      in_valid_ff && !advance, in_valid_ff,
      "pending input beat lost")

   `ACCR_ASSERT_SAME(a_stall_blocks_draw, clock, reset,
      in_valid_ff && (in_kind_ff == accr_pkg::KindDraw) && out_blocked, !advance,
      "draw advanced over a stalled output beat")

endmodule
